// ===== rtl/core/sparse_table_comb_packer_defines.svh =====
// Assertion macros for the sparse table comb packer.
// Assumes clk and rst_n in the scope of each use.
`ifndef SPARSE_TABLE_COMB_PACKER_DEFINES_SVH
`define SPARSE_TABLE_COMB_PACKER_DEFINES_SVH
`ifndef SYNTH
`define STCP_ASSERT(label, prop) label: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("stcp assertion failed");
`define STCP_NEVER(label, expr) label: assert property (@(posedge clk) disable iff (!rst_n) \
  !(expr)) else $error("stcp forbidden condition");
`else
`define STCP_ASSERT(label, prop)
`define STCP_NEVER(label, expr)
`endif
`endif

// ===== rtl/core/stcp_pkg.sv =====
// Package for the sparse table comb packer: sizes, codes and the table request type.
// No dependencies.
package stcp_pkg;
  localparam int TD     = 4096;
  localparam int TAW    = $clog2(TD);
  localparam int LFW    = TAW + 1;
  localparam int VMAX   = 256;
  localparam int PAW    = $clog2(VMAX);
  localparam int PCW    = PAW + 1;
  localparam int MAXV   = 1024;
  localparam int UAW    = $clog2(MAXV);
  localparam int UCW    = UAW + 1;
  localparam int KW     = (UCW > PCW) ? UCW : PCW;
  localparam int OFW    = TAW + 2;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 15;
  localparam int CHK_W  = 13;
  localparam int OFF_W  = 13;
  localparam int HM_W   = 12;
  localparam int ST_W   = 2;

  localparam logic [CHK_W-1:0] CHK_EMPTY = '1;
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_LONG = 2'd2;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic             we;
    logic [TAW-1:0]   waddr;
    logic [VAL_W-1:0] wval;
    logic [CHK_W-1:0] wchk;
    logic [TAW-1:0]   raddr;
  } tbl_req_t;
endpackage

// ===== rtl/core/stcp_ifs.sv =====
// Input and result channel interfaces of the sparse table comb packer.
// Depends on stcp_pkg.
interface stcp_in_if import stcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [IDX_W-1:0] entry_index;
  logic [VAL_W-1:0] entry_value;
  logic             last_entry;
  logic [IDX_W-1:0] read_address;
  modport source (output valid, command, entry_index, entry_value, last_entry, read_address,
                  input ready);
  modport sink (input valid, command, entry_index, entry_value, last_entry, read_address,
                output ready);
endinterface

interface stcp_out_if import stcp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OFF_W-1:0] placed_offset;
  logic [HM_W-1:0]         high_mark;
  logic [ST_W-1:0]         status;
  logic [VAL_W-1:0]        table_word;
  logic signed [CHK_W-1:0] check_word;
  modport source (output valid, placed_offset, high_mark, status, table_word, check_word,
                  input ready);
  modport sink (input valid, placed_offset, high_mark, status, table_word, check_word,
                output ready);
endinterface

// ===== rtl/core/stcp_table.sv =====
// Shared value/check table: one write port, one registered read port, clearing pass.
// Depends on stcp_pkg.
module stcp_table import stcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_req_t         req,
  output logic [VAL_W-1:0] rd_val,
  output logic [CHK_W-1:0] rd_chk,
  output logic             busy
);
  logic [VAL_W-1:0] val_mem [TD];
  logic [CHK_W-1:0] chk_mem [TD];
  logic             clr_r, clr_nxt;
  logic [TAW-1:0]   clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == TAW'(TD - 1)) clr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      val_mem[clr_cnt_r] <= '0;
      chk_mem[clr_cnt_r] <= CHK_EMPTY;
    end else if (req.we) begin
      val_mem[req.waddr] <= req.wval;
      chk_mem[req.waddr] <= req.wchk;
    end
    rd_val <= val_mem[req.raddr];
    rd_chk <= chk_mem[req.raddr];
  end

  assign busy = clr_r;
endmodule

// ===== rtl/core/stcp_ctrl.sv =====
// Packing sequencer: pending vector buffer, used-offset list and the offset search.
// Depends on stcp_pkg, stcp_ifs and the assertion macro header.
`include "sparse_table_comb_packer_defines.svh"
module stcp_ctrl import stcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  stcp_in_if.sink          in_if,
  stcp_out_if.source       out_if,
  input  logic             tbl_busy,
  input  logic [VAL_W-1:0] tbl_val,
  input  logic [CHK_W-1:0] tbl_chk,
  output tbl_req_t         tbl_req
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MM_A  = 4'd1;
  localparam logic [3:0] S_MM_D  = 4'd2;
  localparam logic [3:0] S_TRY   = 4'd3;
  localparam logic [3:0] S_US_A  = 4'd4;
  localparam logic [3:0] S_US_D  = 4'd5;
  localparam logic [3:0] S_SL_A  = 4'd6;
  localparam logic [3:0] S_SL_B  = 4'd7;
  localparam logic [3:0] S_SL_D  = 4'd8;
  localparam logic [3:0] S_WR_A  = 4'd9;
  localparam logic [3:0] S_WR_B  = 4'd10;
  localparam logic [3:0] S_PUSH  = 4'd11;
  localparam logic [3:0] S_LF_A  = 4'd12;
  localparam logic [3:0] S_LF_D  = 4'd13;
  localparam logic [3:0] S_RD_D  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;
  localparam logic signed [OFW-1:0] TD_S = OFW'(TD);

  logic [3:0]              state_r, state_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic signed [OFW-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]        min_r, min_nxt, max_r, max_nxt;
  logic [PCW-1:0]          pcnt_r, pcnt_nxt;
  logic                    tl_r, tl_nxt;
  logic [UCW-1:0]          ucnt_r, ucnt_nxt;
  logic [LFW-1:0]          lf_r, lf_nxt;
  logic [HM_W-1:0]         hi_r, hi_nxt;
  logic [OFF_W-1:0]        res_off_r, res_off_nxt;
  logic [ST_W-1:0]         res_st_r, res_st_nxt;
  logic [VAL_W-1:0]        res_tw_r, res_tw_nxt;
  logic [CHK_W-1:0]        res_cw_r, res_cw_nxt;
  logic                    pk_r, pk_nxt;
  logic                    ov_r, ov_nxt;
  logic [OFF_W-1:0]        o_off_r, o_off_nxt;
  logic [HM_W-1:0]         o_hm_r, o_hm_nxt;
  logic [ST_W-1:0]         o_st_r, o_st_nxt;
  logic [VAL_W-1:0]        o_tw_r, o_tw_nxt;
  logic [CHK_W-1:0]        o_cw_r, o_cw_nxt;

  logic [IDX_W-1:0] pidx_mem [VMAX];
  logic [VAL_W-1:0] pval_mem [VMAX];
  logic [OFF_W-1:0] uoff_mem [MAXV];
  logic [IDX_W-1:0] pidx_q;
  logic [VAL_W-1:0] pval_q;
  logic [OFF_W-1:0] uoff_q;
  logic             p_we, u_we;
  logic             accept;
  logic signed [OFW-1:0] loc, span;
  logic [KW-1:0]    k_inc;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && !tbl_busy;
  assign loc   = j_r + $signed({2'b00, pidx_q});
  assign span  = j_r + $signed({2'b00, max_r});
  assign k_inc = k_r + 1'b1;

  always_comb begin
    state_nxt = state_r; k_nxt = k_r; j_nxt = j_r; min_nxt = min_r; max_nxt = max_r;
    pcnt_nxt = pcnt_r; tl_nxt = tl_r; ucnt_nxt = ucnt_r; lf_nxt = lf_r; hi_nxt = hi_r;
    res_off_nxt = res_off_r; res_st_nxt = res_st_r; res_tw_nxt = res_tw_r;
    res_cw_nxt = res_cw_r; pk_nxt = pk_r;
    ov_nxt = ov_r; o_off_nxt = o_off_r; o_hm_nxt = o_hm_r; o_st_nxt = o_st_r;
    o_tw_nxt = o_tw_r; o_cw_nxt = o_cw_r;
    p_we = 1'b0; u_we = 1'b0;
    tbl_req = '0;
    tbl_req.raddr = in_if.read_address[TAW-1:0];
    if (ov_r && out_if.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_off_nxt = '0; res_st_nxt = ST_OK; res_tw_nxt = '0; res_cw_nxt = '0;
          pk_nxt = (in_if.command == CMD_LOAD);
          if (in_if.command == CMD_READ) begin
            state_nxt = S_RD_D;
          end else begin
            if (pcnt_r < PCW'(VMAX)) begin
              p_we = 1'b1;
              pcnt_nxt = pcnt_r + 1'b1;
            end else begin
              tl_nxt = 1'b1;
            end
            if (in_if.last_entry) begin
              min_nxt = '1; max_nxt = '0; k_nxt = '0;
              if (tl_r || pcnt_r == PCW'(VMAX)) begin
                res_st_nxt = ST_LONG; state_nxt = S_DONE;
              end else if (ucnt_r >= UCW'(MAXV)) begin
                res_st_nxt = ST_FULL; state_nxt = S_DONE;
              end else begin
                state_nxt = S_MM_A;
              end
            end
          end
        end
      end
      S_MM_A: state_nxt = S_MM_D;
      S_MM_D: begin
        if (pidx_q < min_r) min_nxt = pidx_q;
        if (pidx_q > max_r) max_nxt = pidx_q;
        k_nxt = k_inc;
        if (k_inc == KW'(pcnt_r)) begin
          state_nxt = S_TRY;
          j_nxt = $signed({1'b0, lf_r}) - $signed({2'b00, (pidx_q < min_r) ? pidx_q : min_r});
        end else begin
          state_nxt = S_MM_A;
        end
      end
      S_TRY: begin
        k_nxt = '0;
        if (span >= TD_S) begin
          res_st_nxt = ST_FULL; state_nxt = S_DONE;
        end else if (j_r == '0) begin
          j_nxt = j_r + 1'b1;
        end else if (ucnt_r == '0) begin
          state_nxt = S_SL_A;
        end else begin
          state_nxt = S_US_A;
        end
      end
      S_US_A: state_nxt = S_US_D;
      S_US_D: begin
        if (uoff_q == j_r[OFF_W-1:0]) begin
          j_nxt = j_r + 1'b1; state_nxt = S_TRY;
        end else if (k_inc == KW'(ucnt_r)) begin
          k_nxt = '0; state_nxt = S_SL_A;
        end else begin
          k_nxt = k_inc; state_nxt = S_US_A;
        end
      end
      S_SL_A: state_nxt = S_SL_B;
      S_SL_B: begin
        tbl_req.raddr = loc[TAW-1:0];
        if (loc[OFW-1]) begin
          j_nxt = j_r + 1'b1; state_nxt = S_TRY;
        end else begin
          state_nxt = S_SL_D;
        end
      end
      S_SL_D: begin
        if (tbl_chk != CHK_EMPTY) begin
          j_nxt = j_r + 1'b1; state_nxt = S_TRY;
        end else if (k_inc == KW'(pcnt_r)) begin
          k_nxt = '0; state_nxt = S_WR_A;
        end else begin
          k_nxt = k_inc; state_nxt = S_SL_A;
        end
      end
      S_WR_A: state_nxt = S_WR_B;
      S_WR_B: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = loc[TAW-1:0];
        tbl_req.wval  = pval_q;
        tbl_req.wchk  = {1'b0, pidx_q};
        if (loc[HM_W-1:0] > hi_r) hi_nxt = loc[HM_W-1:0];
        k_nxt = k_inc;
        state_nxt = (k_inc == KW'(pcnt_r)) ? S_PUSH : S_WR_A;
      end
      S_PUSH: begin
        u_we = 1'b1;
        ucnt_nxt = ucnt_r + 1'b1;
        res_off_nxt = j_r[OFF_W-1:0];
        state_nxt = S_LF_A;
      end
      S_LF_A: begin
        tbl_req.raddr = lf_r[TAW-1:0];
        state_nxt = (lf_r >= LFW'(TD)) ? S_DONE : S_LF_D;
      end
      S_LF_D: begin
        if (tbl_chk != CHK_EMPTY) begin
          lf_nxt = lf_r + 1'b1; state_nxt = S_LF_A;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD_D: begin
        res_tw_nxt = tbl_val; res_cw_nxt = tbl_chk; state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          o_off_nxt = res_off_r; o_hm_nxt = hi_r; o_st_nxt = res_st_r;
          o_tw_nxt = res_tw_r; o_cw_nxt = res_cw_r;
          // only a pack transaction clears the buffer; a read leaves it alone
          if (pk_r) begin
            pcnt_nxt = '0; tl_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pcnt_r <= '0; tl_r <= 1'b0; ucnt_r <= '0; lf_r <= '0;
      hi_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pcnt_r <= pcnt_nxt; tl_r <= tl_nxt; ucnt_r <= ucnt_nxt;
      lf_r <= lf_nxt; hi_r <= hi_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt; j_r <= j_nxt; min_r <= min_nxt; max_r <= max_nxt;
    res_off_r <= res_off_nxt; res_st_r <= res_st_nxt; res_tw_r <= res_tw_nxt;
    res_cw_r <= res_cw_nxt; pk_r <= pk_nxt;
    o_off_r <= o_off_nxt; o_hm_r <= o_hm_nxt; o_st_r <= o_st_nxt;
    o_tw_r <= o_tw_nxt; o_cw_r <= o_cw_nxt;
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pidx_mem[pcnt_r[PAW-1:0]] <= in_if.entry_index;
      pval_mem[pcnt_r[PAW-1:0]] <= in_if.entry_value;
    end
    if (u_we) uoff_mem[ucnt_r[UAW-1:0]] <= j_r[OFF_W-1:0];
    pidx_q <= pidx_mem[k_r[PAW-1:0]];
    pval_q <= pval_mem[k_r[PAW-1:0]];
    uoff_q <= uoff_mem[k_r[UAW-1:0]];
  end

  assign out_if.valid         = ov_r;
  assign out_if.placed_offset = o_off_r;
  assign out_if.high_mark     = o_hm_r;
  assign out_if.status        = o_st_r;
  assign out_if.table_word    = o_tw_r;
  assign out_if.check_word    = o_cw_r;

  `STCP_ASSERT(a_lf_mono, $past(rst_n) |-> lf_r >= $past(lf_r))
  `STCP_NEVER(a_ucnt_max, ucnt_r > UCW'(MAXV))
  `STCP_NEVER(a_pcnt_max, pcnt_r > PCW'(VMAX))
  `STCP_NEVER(a_we_idle, state_r == S_IDLE && tbl_req.we)
endmodule

// ===== rtl/core/sparse_table_comb_packer.sv =====
// Sparse table comb packer: first-fit displacement packing of sparse vectors into one
// shared 4096-slot value/check table. After reset a clearing pass over all 4096 slots
// runs before the first transaction is taken. The last entry of a vector starts the
// offset search, unless the vector is too long or the used-offset list is full, on one
// shared adder/compare sequenced over the pending buffer, the used-offset list and the
// table read port: a min/max scan of the pending entries; for each offset tried, a check
// against each used offset and a slot probe per entry; a write of each entry; and a step
// of the lowest-free pointer past each occupied slot. It takes one transaction at a time.
// Depends on stcp_pkg, stcp_ifs, stcp_table and stcp_ctrl.
module sparse_table_comb_packer import stcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stcp_in_if.sink    in_if,
  stcp_out_if.source out_if
);
  tbl_req_t         tbl_req;
  logic [VAL_W-1:0] tbl_val;
  logic [CHK_W-1:0] tbl_chk;
  logic             tbl_busy;

  stcp_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tbl_req),
    .rd_val (tbl_val),
    .rd_chk (tbl_chk),
    .busy   (tbl_busy)
  );

  stcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .tbl_busy (tbl_busy),
    .tbl_val  (tbl_val),
    .tbl_chk  (tbl_chk),
    .tbl_req  (tbl_req)
  );
endmodule
